>>> rtl/core/pfb_pkg.sv
// Package with the item types and function codes of the ping-pong frame buffer control.
`default_nettype none
package pfb_pkg;

  localparam int unsigned LenW = 16;

  typedef enum logic [2:0] {
    FUNC_ACQUIRE  = 3'd0,
    FUNC_COMPLETE = 3'd1,
    FUNC_ERROR    = 3'd2,
    FUNC_STATE    = 3'd3,
    FUNC_DATA     = 3'd4,
    FUNC_RELEASE  = 3'd5
  } func_e_t;

  typedef enum logic [1:0] {
    FSTATE_IDLE     = 2'd0,
    FSTATE_COMPLETE = 2'd1,
    FSTATE_ERROR    = 2'd2
  } fstate_e_t;

  typedef struct packed {
    logic [2:0]      func;
    logic [LenW-1:0] rcv_bytes;
  } in_item_t;

  typedef struct packed {
    logic            granted;
    logic            buffer_index;
    logic [1:0]      frame_state;
    logic [LenW-1:0] frame_bytes;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic drain;
  } in_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/pfb_in_reg.sv
// Input register that holds one accepted item until the slot logic takes it.
`default_nettype none
module pfb_in_reg (
  input  wire               clk,
  input  wire               rst_n,
  input  pfb_pkg::in_ctrl_t ctrl,
  input  pfb_pkg::in_item_t item_in,
  output logic              valid,
  output pfb_pkg::in_item_t item_out
);
  import pfb_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  always_comb begin
    priority if (ctrl.load) begin
      valid_nxt = 1'b1;
    end else if (ctrl.drain) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item_r <= item_in;
    end
  end

  assign valid    = valid_r;
  assign item_out = item_r;

endmodule
`default_nettype wire

>>> rtl/core/pfb_slot_ctrl.sv
// Slot state registers and the combinational logic that executes one function item.
`default_nettype none
module pfb_slot_ctrl #(
  parameter int unsigned BUFFER_BYTES = 16384
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                step,
  input  pfb_pkg::in_item_t  item,
  output pfb_pkg::out_item_t res
);
  import pfb_pkg::*;

  localparam logic [LenW-1:0] MaxLen = LenW'(BUFFER_BYTES);

  logic            receive_slot_r, receive_slot_nxt;
  logic            process_slot_r, process_slot_nxt;
  logic [1:0]      complete_r, complete_nxt;
  logic [1:0]      error_r, error_nxt;
  logic [LenW-1:0] length_r [2];
  logic [LenW-1:0] length_nxt [2];
  logic            rx;
  logic            other;
  logic            rx_busy;
  logic            other_busy;

  assign rx         = receive_slot_r;
  assign other      = ~receive_slot_r;
  assign rx_busy    = complete_r[rx] | error_r[rx];
  assign other_busy = complete_r[other] | error_r[other];

  always_comb begin
    receive_slot_nxt = receive_slot_r;
    process_slot_nxt = process_slot_r;
    complete_nxt     = complete_r;
    error_nxt        = error_r;
    length_nxt       = length_r;
    res              = '0;
    unique case (item.func)
      FUNC_ACQUIRE: begin
        if (!rx_busy) begin
          length_nxt[rx]   = '0;
          res.granted      = 1'b1;
          res.buffer_index = rx;
        end else if (!other_busy) begin
          receive_slot_nxt  = other;
          length_nxt[other] = '0;
          res.granted       = 1'b1;
          res.buffer_index  = other;
        end else begin
          res.buffer_index = rx;
        end
      end
      FUNC_COMPLETE: begin
        if (item.rcv_bytes > MaxLen) begin
          error_nxt[rx] = 1'b1;
        end else begin
          length_nxt[rx]   = item.rcv_bytes;
          complete_nxt[rx] = 1'b1;
        end
      end
      FUNC_ERROR: begin
        error_nxt[rx] = 1'b1;
      end
      FUNC_STATE: begin
        priority if (error_r[other]) begin
          process_slot_nxt = other;
          res.frame_state  = FSTATE_ERROR;
        end else if (error_r[rx]) begin
          process_slot_nxt = rx;
          res.frame_state  = FSTATE_ERROR;
        end else if (complete_r[other]) begin
          process_slot_nxt = other;
          res.frame_state  = FSTATE_COMPLETE;
        end else if (complete_r[rx]) begin
          process_slot_nxt = rx;
          res.frame_state  = FSTATE_COMPLETE;
        end else begin
          res.frame_state = FSTATE_IDLE;
        end
        res.buffer_index = process_slot_nxt;
      end
      FUNC_DATA: begin
        res.buffer_index = process_slot_r;
        res.frame_bytes  = length_r[process_slot_r];
      end
      FUNC_RELEASE: begin
        length_nxt[process_slot_r]   = '0;
        complete_nxt[process_slot_r] = 1'b0;
        error_nxt[process_slot_r]    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receive_slot_r <= 1'b0;
      process_slot_r <= 1'b0;
      complete_r     <= '0;
      error_r        <= '0;
      length_r[0]    <= '0;
      length_r[1]    <= '0;
    end else if (step) begin
      receive_slot_r <= receive_slot_nxt;
      process_slot_r <= process_slot_nxt;
      complete_r     <= complete_nxt;
      error_r        <= error_nxt;
      length_r[0]    <= length_nxt[0];
      length_r[1]    <= length_nxt[1];
    end
  end

  // A granted acquire leaves the receiving slot free and empty.
  a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.granted) |=> (length_r[receive_slot_r] == '0 &&
                               !complete_r[receive_slot_r] && !error_r[receive_slot_r]))
    else $error("granted slot is not free");

  // A release frees the processing slot.
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.func == FUNC_RELEASE) |=>
      (!complete_r[process_slot_r] && !error_r[process_slot_r]))
    else $error("released slot still marked");

  // No stored length ever exceeds the buffer size.
  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (length_r[0] <= MaxLen && length_r[1] <= MaxLen))
    else $error("stored length above buffer size");

endmodule
`default_nettype wire

>>> rtl/core/ping_pong_frame_buffer_control_core.sv
// Top level of the ping-pong frame buffer control: handshakes and result register.
// An accepted item goes from the input register through the slot logic into the result register.
// Throughput: one item per cycle unless the result channel stalls; the slot logic is combinational.
// Stalls on the result channel back up through the input register to in_stall.
// Synchronous active-low reset clears all slot marks, lengths and slot pointers.
`default_nettype none
module ping_pong_frame_buffer_control_core #(
  parameter int unsigned BUFFER_BYTES = 16384
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  pfb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  wire                out_stall,
  output pfb_pkg::out_item_t out_item
);
  import pfb_pkg::*;

  in_ctrl_t  in_ctrl;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;
  logic      step;
  out_item_t res;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  assign advance       = !out_valid_r || !out_stall;
  assign step          = s1_valid && advance;
  assign in_stall      = s1_valid && !advance;
  assign in_ctrl.load  = in_valid && !in_stall;
  assign in_ctrl.drain = step;

  pfb_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (in_ctrl),
    .item_in  (in_item),
    .valid    (s1_valid),
    .item_out (s1_item)
  );

  pfb_slot_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_slot_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_item),
    .res   (res)
  );

  always_comb begin
    priority if (advance) begin
      out_valid_nxt = s1_valid;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

>>> tb/ping_pong_frame_buffer_control_core_tb.sv
// Self-checking testbench for the ping-pong frame buffer control core.
`default_nettype none
module ping_pong_frame_buffer_control_core_tb;
  import pfb_pkg::*;

  localparam int unsigned BufBytes = 16384;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [2:0] FuncUnusedLo = 3'd6;
  localparam logic [2:0] FuncUnusedHi = 3'd7;

  typedef struct packed {
    logic     hold;
    in_item_t item;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  pending_t pending_items[$];
  out_item_t expected_results[$];

  logic rx_slot = 1'b0;
  logic proc_slot = 1'b0;
  logic [1:0] done_mark = '0;
  logic [1:0] err_mark = '0;
  logic [LenW-1:0] stored_len[2] = '{default: '0};

  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned refused_cnt = 0;
  int unsigned overlong_cnt = 0;
  int unsigned pause_cnt = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned stall_pct = 0;

  ping_pong_frame_buffer_control_core #(
    .BUFFER_BYTES(BufBytes)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic slot_busy(logic s);
    return done_mark[s] | err_mark[s];
  endfunction

  function automatic out_item_t frame_ctrl_predict(in_item_t it);
    out_item_t r;
    logic rx;
    logic oth;
    r = '0;
    rx = rx_slot;
    oth = ~rx_slot;
    case (it.func)
      FUNC_ACQUIRE: begin
        if (slot_busy(rx) && slot_busy(oth)) begin
          r.buffer_index = rx;
          refused_cnt++;
        end else begin
          if (slot_busy(rx)) begin
            rx = oth;
            rx_slot = rx;
          end
          stored_len[rx] = '0;
          r.granted = 1'b1;
          r.buffer_index = rx;
        end
      end
      FUNC_COMPLETE: begin
        if (it.rcv_bytes > BufBytes) begin
          err_mark[rx] = 1'b1;
          overlong_cnt++;
        end else begin
          stored_len[rx] = it.rcv_bytes;
          done_mark[rx] = 1'b1;
        end
      end
      FUNC_ERROR: err_mark[rx] = 1'b1;
      FUNC_STATE: begin
        if (err_mark[oth]) begin
          proc_slot = oth;
          r.frame_state = FSTATE_ERROR;
        end else if (err_mark[rx]) begin
          proc_slot = rx;
          r.frame_state = FSTATE_ERROR;
        end else if (done_mark[oth]) begin
          proc_slot = oth;
          r.frame_state = FSTATE_COMPLETE;
        end else if (done_mark[rx]) begin
          proc_slot = rx;
          r.frame_state = FSTATE_COMPLETE;
        end
        r.buffer_index = proc_slot;
      end
      FUNC_DATA: begin
        r.buffer_index = proc_slot;
        r.frame_bytes = stored_len[proc_slot];
      end
      FUNC_RELEASE: begin
        stored_len[proc_slot] = '0;
        done_mark[proc_slot] = 1'b0;
        err_mark[proc_slot] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_item(logic [2:0] func, logic [LenW-1:0] len, logic hold = 1'b0);
    pending_t p;
    p.hold = hold;
    p.item.func = func;
    p.item.rcv_bytes = len;
    pending_items.push_back(p);
  endtask

  function automatic logic [LenW-1:0] frame_len();
    case ($urandom_range(9))
      0: return '0;
      1: return LenW'(BufBytes);
      2: return LenW'(BufBytes + 1);
      3: return '1;
      4, 5: return LenW'($urandom_range(65535));
      default: return LenW'($urandom_range(BufBytes));
    endcase
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    pending_t nxt_p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(frame_ctrl_predict(in_item));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_items[0].hold && expected_results.size() != 0) begin
          in_valid <= 1'b0;
        end else if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          if (pending_items[0].hold) pause_cnt++;
          nxt_p = pending_items.pop_front();
          in_item <= nxt_p.item;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(3))
              0: begin
                burst_left = $urandom_range(1, 4);
                gap_left = $urandom_range(1, 3);
              end
              1: begin
                burst_left = $urandom_range(5, 30);
                gap_left = $urandom_range(0, 10);
              end
              2: begin
                burst_left = $urandom_range(50, 120);
                gap_left = 0;
              end
              default: begin
                burst_left = $urandom_range(1, 10);
                gap_left = $urandom_range(10, 40);
              end
            endcase
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt % 64 == 0) begin
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result arrived with no item outstanding");
        fail_cnt++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("granted", 32'(exp_r.granted), 32'(out_item.granted));
        check_field("buffer_index", 32'(exp_r.buffer_index), 32'(out_item.buffer_index));
        check_field("frame_state", 32'(exp_r.frame_state), 32'(out_item.frame_state));
        check_field("frame_bytes", 32'(exp_r.frame_bytes), 32'(out_item.frame_bytes));
        checked_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned total;
    add_item(FUNC_STATE, '0);
    add_item(FUNC_DATA, '1);
    add_item(FUNC_RELEASE, '0);
    add_item(FUNC_ACQUIRE, '1);
    add_item(FUNC_COMPLETE, '0);
    add_item(FUNC_ACQUIRE, '0);
    add_item(FUNC_COMPLETE, LenW'(BufBytes));
    add_item(FUNC_ACQUIRE, '0);
    add_item(FUNC_STATE, '0);
    add_item(FUNC_DATA, '0);
    add_item(FUNC_RELEASE, '0);
    add_item(FUNC_STATE, '0);
    add_item(FUNC_DATA, '0);
    add_item(FUNC_RELEASE, '0);
    add_item(FUNC_RELEASE, '1);
    add_item(FUNC_ACQUIRE, '0);
    add_item(FUNC_COMPLETE, LenW'(BufBytes + 1));
    add_item(FUNC_ACQUIRE, '0);
    add_item(FUNC_ERROR, '0);
    add_item(FUNC_STATE, '0);
    add_item(FUNC_RELEASE, '0);
    add_item(FUNC_STATE, '0);
    add_item(FUNC_DATA, '0);
    add_item(FuncUnusedLo, '1);
    add_item(FuncUnusedHi, 16'h5555);
    add_item(FUNC_COMPLETE, '1, 1'b1);

    while (pending_items.size() < 826) begin
      if ($urandom_range(9) < 2) begin
        add_item(3'($urandom_range(7)), LenW'($urandom_range(65535)),
                 $urandom_range(149) == 0);
      end else begin
        add_item(FUNC_ACQUIRE, LenW'($urandom_range(65535)), $urandom_range(149) == 0);
        if ($urandom_range(3) == 0) add_item(FUNC_ERROR, LenW'($urandom_range(65535)));
        else add_item(FUNC_COMPLETE, frame_len());
        if ($urandom_range(1) == 1) begin
          add_item(FUNC_ACQUIRE, LenW'($urandom_range(65535)));
          add_item(FUNC_COMPLETE, frame_len());
        end
        add_item(FUNC_STATE, LenW'($urandom_range(65535)));
        add_item(FUNC_DATA, LenW'($urandom_range(65535)));
        if ($urandom_range(3) != 0) add_item(FUNC_RELEASE, LenW'($urandom_range(65535)));
        if ($urandom_range(4) == 0) add_item(FUNC_RELEASE, LenW'($urandom_range(65535)));
      end
    end
    total = pending_items.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("summary: %0d items sent, %0d results checked, %0d pauses until drained",
             accepted_cnt, checked_cnt, pause_cnt);
    $display("summary: %0d refused acquires, %0d over-long frames flagged as errors",
             refused_cnt, overlong_cnt);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
